// ===== rtl/spnp_pkg.sv =====
`default_nettype none
package spnp_pkg;

  localparam int MAX_STEPS_DEF = 1024;
  localparam int SINE_TABLE_SIZE_DEF = 1024;
  localparam int FRAC_BITS_DEF = 16;

  localparam longint HALF_PI_Q30 = 64'd1686629713;

  localparam logic [1:0] REG_PATH_MODE = 2'd0;
  localparam logic [1:0] REG_FORWARD_SPEED = 2'd1;
  localparam logic [1:0] REG_WAVE_AMPLITUDE = 2'd2;
  localparam logic [1:0] REG_WAVE_PERIOD = 2'd3;

  localparam logic [30:0] FORWARD_SPEED_RST = 31'd65536;

  typedef enum logic [4:0] {
    S_IDLE, S_TM_GO, S_TM_WAIT, S_WIN, S_XB0, S_XB1, S_XB2,
    S_SM_GO, S_SM_WAIT, S_OM_GO, S_OM_WAIT, S_P_GO, S_P_WAIT,
    S_ROM, S_YMUL, S_YSET, S_MAG, S_DX0, S_DX1, S_DY0, S_DY1, S_CMP
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/spnp_divider.sv =====
`default_nettype none
module spnp_divider #(
  parameter int DW = 48,
  parameter int VW = 31,
  parameter int CW = 6
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          go,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  input  wire logic [CW-1:0] iters,
  output logic      [DW-1:0] quotient,
  output logic      [VW-1:0] remainder,
  output logic               done
);

  logic [DW-1:0] q;
  logic [VW-1:0] r;
  logic [VW-1:0] dv;
  logic [CW-1:0] cnt;
  logic          running;
  logic [VW:0]   sh;
  logic [VW:0]   diff;
  logic          ge;

  always_comb begin
    sh = {r, q[DW-1]};
    diff = sh - {1'b0, dv};
    ge = sh >= {1'b0, dv};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        q <= dividend << (CW'(DW) - iters);
        r <= VW'(dividend >> iters);
        dv <= divisor;
        cnt <= iters;
        running <= 1'b1;
      end else if (running) begin
        q <= {q[DW-2:0], ge};
        r <= ge ? diff[VW-1:0] : sh[VW-1:0];
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = q;
  assign remainder = r;

endmodule
`default_nettype wire

// ===== rtl/sinusoid_path_nearest_point.sv =====
// Straight-line mode gives the result in the cycle after start, and busy stays low.
// Sinusoidal mode first runs a setup, mostly in the shared divider (the phase divisions
// are skipped for a zero period, and an empty window ends it with the origin fallback),
// then handles one sample at a time, for at most MAX_STEPS samples; the serial divider and
// the shared multiplier do its arithmetic (no divide per sample when the period is zero).
// The next word is taken once busy is low; done marks each result for one cycle, and
// synchronous reset returns the sequencer to idle and the registers to their defaults.
`default_nettype none
module sinusoid_path_nearest_point #(
  parameter int MAX_STEPS = spnp_pkg::MAX_STEPS_DEF,
  parameter int SINE_TABLE_SIZE = spnp_pkg::SINE_TABLE_SIZE_DEF,
  parameter int FRAC_BITS = spnp_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] query_x,
  input  wire logic signed [31:0] query_y,
  output logic                    done,
  output logic signed [31:0]      near_x,
  output logic signed [31:0]      near_y,
  output logic                    origin_fallback,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  localparam int FB = FRAC_BITS;
  localparam int N = SINE_TABLE_SIZE;
  localparam int QB = $clog2(4 * N);
  localparam int AW = $clog2(N + 1);
  localparam int KW = $clog2(MAX_STEPS + 1);
  localparam int DW = ((32 + FB) > (26 + QB)) ? (32 + FB) : (26 + QB);
  localparam int VW = 31;
  localparam int CW = $clog2(DW + 1);
  localparam int MBA = ((FB + 2) > 18) ? (FB + 2) : 18;
  localparam int MB = (MBA > (32 - FB)) ? MBA : (32 - FB);
  localparam int PW = 34 + MB;
  localparam int XWA = ((62 - FB) > ($clog2(MAX_STEPS) + 31)) ? (62 - FB)
                     : ($clog2(MAX_STEPS) + 31);
  localparam int XW = XWA + 1;
  localparam logic [QB:0] N1 = (QB + 1)'(N);
  localparam logic [QB:0] N2 = (QB + 1)'(2 * N);
  localparam logic [QB:0] N3 = (QB + 1)'(3 * N);

  logic                 path_mode;
  logic [30:0]          forward_speed;
  logic signed [31:0]   wave_amplitude;
  logic [25:0]          wave_period;

  spnp_pkg::state_t     state, state_next;

  logic signed [31:0]   qx, qy, tm, sy, sxr, bx, by;
  logic [30:0]          start_t;
  logic [KW-1:0]        n_steps, k;
  logic [XW-1:0]        xacc;
  logic [25:0]          rem, dstep;
  logic [QB-1:0]        p;
  logic [FB:0]          sine_q;
  logic                 sine_neg;
  logic [32:0]          mx, my;
  logic [65:0]          acc, best;
  logic signed [PW-1:0] prod;
  logic signed [33:0]   mul_a;
  logic signed [MB-1:0] mul_b;

  logic                 div_go, div_done;
  logic [DW-1:0]        div_dividend, div_quot;
  logic [VW-1:0]        div_divisor, div_rem;
  logic [CW-1:0]        div_iters;

  logic [30:0]          a_eff;
  logic [31:0]          qx_mag;
  logic [FB:0]          sine_tbl [N+1];

  for (genvar i = 0; i <= N; i++) begin : g_rom
    localparam longint TH = (spnp_pkg::HALF_PI_Q30 * i) / N;
    localparam longint T2 = (TH * TH) >> 30;
    localparam longint C1 = ((TH * T2) >> 30) / 6;
    localparam longint C2 = ((C1 * T2) >> 30) / 20;
    localparam longint C3 = ((C2 * T2) >> 30) / 42;
    localparam longint C4 = ((C3 * T2) >> 30) / 72;
    localparam longint C5 = ((C4 * T2) >> 30) / 110;
    localparam longint C6 = ((C5 * T2) >> 30) / 156;
    localparam longint C7 = ((C6 * T2) >> 30) / 210;
    localparam longint C8 = ((C7 * T2) >> 30) / 272;
    localparam longint C9 = ((C8 * T2) >> 30) / 342;
    localparam longint C10 = ((C9 * T2) >> 30) / 420;
    localparam longint SM = TH - C1 + C2 - C3 + C4 - C5 + C6 - C7 + C8 - C9 + C10;
    localparam longint SC = (SM < 0) ? 64'sd0 : SM;
    localparam longint RV = (SC + (longint'(1) << (29 - FB))) >>> (30 - FB);
    localparam longint CV = (RV > (longint'(1) << FB)) ? (longint'(1) << FB) : RV;
    assign sine_tbl[i] = (FB + 1)'(CV);
  end

  spnp_divider #(.DW(DW), .VW(VW), .CW(CW)) u_div (
    .clk(clk), .rst(rst), .go(div_go), .dividend(div_dividend),
    .divisor(div_divisor), .iters(div_iters), .quotient(div_quot),
    .remainder(div_rem), .done(div_done)
  );

  assign a_eff = (forward_speed == 31'd0) ? 31'd1 : forward_speed;
  assign qx_mag = qx[31] ? 32'(-qx) : 32'(qx);
  assign busy = state != spnp_pkg::S_IDLE;

  // Window arithmetic.
  logic signed [33:0] endv, lowv, startv, span;
  logic [26:0]        cnt;
  always_comb begin
    endv = 34'(tm) + $signed({9'b0, wave_period[25:1]});
    lowv = 34'(tm) - $signed({9'b0, wave_period[25:1]});
    startv = lowv[33] ? 34'sd0 : lowv;
    span = endv - startv;
    cnt = 27'(span >>> FB) + 27'd1;
  end

  // Phase index to quadrant and table address.
  logic [QB:0]   pe, rr;
  logic [1:0]    quad;
  logic [AW-1:0] addr;
  always_comb begin
    pe = {1'b0, p};
    if (pe < N1) begin
      quad = 2'd0;
      rr = pe;
    end else if (pe < N2) begin
      quad = 2'd1;
      rr = pe - N1;
    end else if (pe < N3) begin
      quad = 2'd2;
      rr = pe - N2;
    end else begin
      quad = 2'd3;
      rr = pe - N3;
    end
    addr = quad[0] ? AW'(N1 - rr) : AW'(rr);
  end

  logic [31:0]          sx_c;
  logic signed [33:0]   dxv;
  logic signed [32:0]   dyv;
  logic signed [PW-1:0] ys;
  logic                 y_ov;
  logic [65:0]          sq_sum;
  logic                 take, last;
  logic [26:0]          rsum;
  always_comb begin
    sx_c = (xacc > XW'(32'h7fffffff)) ? 32'h7fffffff : xacc[31:0];
    dxv = $signed({2'b0, sx_c}) - 34'(qx);
    dyv = 33'(sy) - 33'(qy);
    ys = prod >>> FB;
    y_ov = !((&ys[PW-1:31]) || !(|ys[PW-1:31]));
    sq_sum = acc + (66'($unsigned(prod)) << 16);
    take = (k == '0) || (sq_sum < best);
    last = ({1'b0, k} + 1'b1) == {1'b0, n_steps};
    rsum = {1'b0, rem} + {1'b0, dstep};
  end

  always_comb begin
    state_next = state;
    div_go = 1'b0;
    div_dividend = '0;
    div_divisor = VW'(wave_period);
    div_iters = '0;
    mul_a = '0;
    mul_b = '0;
    case (state)
      spnp_pkg::S_IDLE: begin
        if (start && path_mode) state_next = spnp_pkg::S_TM_GO;
      end
      spnp_pkg::S_TM_GO: begin
        div_go = 1'b1;
        div_dividend = DW'({qx_mag, FB'(0)});
        div_divisor = a_eff;
        div_iters = CW'(32 + FB);
        state_next = spnp_pkg::S_TM_WAIT;
      end
      spnp_pkg::S_TM_WAIT: if (div_done) state_next = spnp_pkg::S_WIN;
      spnp_pkg::S_WIN: state_next = endv[33] ? spnp_pkg::S_IDLE : spnp_pkg::S_XB0;
      spnp_pkg::S_XB0: begin
        mul_a = $signed(34'(a_eff));
        mul_b = $signed(MB'(start_t[FB-1:0]));
        state_next = spnp_pkg::S_XB1;
      end
      spnp_pkg::S_XB1: begin
        mul_a = $signed(34'(a_eff));
        mul_b = $signed(MB'(start_t[30:FB]));
        state_next = spnp_pkg::S_XB2;
      end
      spnp_pkg::S_XB2: begin
        state_next = (wave_period == 26'd0) ? spnp_pkg::S_MAG : spnp_pkg::S_SM_GO;
      end
      spnp_pkg::S_SM_GO: begin
        div_go = 1'b1;
        div_dividend = DW'(start_t);
        div_iters = CW'(31);
        state_next = spnp_pkg::S_SM_WAIT;
      end
      spnp_pkg::S_SM_WAIT: if (div_done) state_next = spnp_pkg::S_OM_GO;
      spnp_pkg::S_OM_GO: begin
        div_go = 1'b1;
        div_dividend = DW'(1) << FB;
        div_iters = CW'(FB + 1);
        state_next = spnp_pkg::S_OM_WAIT;
      end
      spnp_pkg::S_OM_WAIT: if (div_done) state_next = spnp_pkg::S_P_GO;
      spnp_pkg::S_P_GO: begin
        div_go = 1'b1;
        div_dividend = DW'(rem) * DW'(4 * N);
        div_iters = CW'(QB);
        state_next = spnp_pkg::S_P_WAIT;
      end
      spnp_pkg::S_P_WAIT: if (div_done) state_next = spnp_pkg::S_ROM;
      spnp_pkg::S_ROM: state_next = spnp_pkg::S_YMUL;
      spnp_pkg::S_YMUL: begin
        mul_a = 34'(wave_amplitude);
        mul_b = sine_neg ? -$signed(MB'(sine_q)) : $signed(MB'(sine_q));
        state_next = spnp_pkg::S_YSET;
      end
      spnp_pkg::S_YSET: state_next = spnp_pkg::S_MAG;
      spnp_pkg::S_MAG: state_next = spnp_pkg::S_DX0;
      spnp_pkg::S_DX0: begin
        mul_a = $signed({1'b0, mx});
        mul_b = $signed(MB'(mx[15:0]));
        state_next = spnp_pkg::S_DX1;
      end
      spnp_pkg::S_DX1: begin
        mul_a = $signed({1'b0, mx});
        mul_b = $signed(MB'(mx[32:16]));
        state_next = spnp_pkg::S_DY0;
      end
      spnp_pkg::S_DY0: begin
        mul_a = $signed({1'b0, my});
        mul_b = $signed(MB'(my[15:0]));
        state_next = spnp_pkg::S_DY1;
      end
      spnp_pkg::S_DY1: begin
        mul_a = $signed({1'b0, my});
        mul_b = $signed(MB'(my[32:16]));
        state_next = spnp_pkg::S_CMP;
      end
      spnp_pkg::S_CMP: begin
        if (last) state_next = spnp_pkg::S_IDLE;
        else if (wave_period == 26'd0) state_next = spnp_pkg::S_MAG;
        else state_next = spnp_pkg::S_P_GO;
      end
      default: state_next = spnp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= spnp_pkg::S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      path_mode <= 1'b0;
      forward_speed <= spnp_pkg::FORWARD_SPEED_RST;
      wave_amplitude <= '0;
      wave_period <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        spnp_pkg::REG_PATH_MODE: path_mode <= cfg_data[0];
        spnp_pkg::REG_FORWARD_SPEED: forward_speed <= cfg_data[30:0];
        spnp_pkg::REG_WAVE_AMPLITUDE: wave_amplitude <= $signed(cfg_data);
        spnp_pkg::REG_WAVE_PERIOD: wave_period <= cfg_data[25:0];
        default: path_mode <= path_mode;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      near_x <= '0;
      near_y <= '0;
      origin_fallback <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        spnp_pkg::S_IDLE: begin
          if (start) begin
            qx <= query_x;
            qy <= query_y;
            if (!path_mode) begin
              near_x <= query_x;
              near_y <= '0;
              origin_fallback <= 1'b0;
              done <= 1'b1;
            end
          end
        end
        spnp_pkg::S_TM_WAIT: begin
          if (div_done) begin
            if (!qx[31]) begin
              tm <= (div_quot > DW'(32'h7fffffff)) ? 32'sh7fffffff : $signed(div_quot[31:0]);
            end else begin
              tm <= (div_quot > DW'(33'h080000000)) ? 32'sh80000000
                  : -$signed(div_quot[31:0]);
            end
          end
        end
        spnp_pkg::S_WIN: begin
          start_t <= startv[30:0];
          n_steps <= (cnt > 27'(MAX_STEPS)) ? KW'(MAX_STEPS) : KW'(cnt);
          k <= '0;
          if (endv[33]) begin
            near_x <= '0;
            near_y <= '0;
            origin_fallback <= 1'b1;
            done <= 1'b1;
          end
        end
        spnp_pkg::S_XB1: xacc <= XW'($unsigned(prod) >> FB);
        spnp_pkg::S_XB2: begin
          xacc <= xacc + XW'($unsigned(prod));
          sy <= '0;
        end
        spnp_pkg::S_SM_WAIT: if (div_done) rem <= div_rem[25:0];
        spnp_pkg::S_OM_WAIT: if (div_done) dstep <= div_rem[25:0];
        spnp_pkg::S_P_WAIT: if (div_done) p <= div_quot[QB-1:0];
        spnp_pkg::S_ROM: begin
          sine_q <= sine_tbl[addr];
          sine_neg <= quad[1];
        end
        spnp_pkg::S_YSET: sy <= y_ov ? (ys[PW-1] ? 32'sh80000000 : 32'sh7fffffff) : ys[31:0];
        spnp_pkg::S_MAG: begin
          sxr <= $signed(sx_c);
          mx <= dxv[33] ? 33'(-dxv) : dxv[32:0];
          my <= dyv[32] ? 33'(-dyv) : 33'(dyv);
        end
        spnp_pkg::S_DX1: acc <= 66'($unsigned(prod));
        spnp_pkg::S_DY0: acc <= acc + (66'($unsigned(prod)) << 16);
        spnp_pkg::S_DY1: acc <= acc + 66'($unsigned(prod));
        spnp_pkg::S_CMP: begin
          if (take) begin
            best <= sq_sum;
            bx <= sxr;
            by <= sy;
          end
          if (last) begin
            near_x <= take ? sxr : bx;
            near_y <= take ? sy : by;
            origin_fallback <= 1'b0;
            done <= 1'b1;
          end else begin
            k <= k + 1'b1;
            xacc <= xacc + XW'(a_eff);
            rem <= (rsum >= {1'b0, wave_period}) ? 26'(rsum - {1'b0, wave_period})
                 : rsum[25:0];
          end
        end
        default: done <= 1'b0;
      endcase
    end
  end

  a_straight: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !path_mode) |=> (done && near_y == 32'sd0 && !origin_fallback))
    else $error("straight-line word not returned on the next cycle");

  a_fallback: assert property (@(posedge clk) disable iff (rst)
    (done && origin_fallback) |-> (near_x == 32'sd0 && near_y == 32'sd0))
    else $error("fallback word without origin");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while sequencer busy");

endmodule
`default_nettype wire
